// File: rtl/tspa_pkg.sv
package tspa_pkg;

    localparam int STAMP_W   = 48;
    localparam int NUM_W     = 32;
    localparam int THR_W     = 24;
    localparam logic [THR_W-1:0] THR_RESET = 24'd10000;

    // action codes
    localparam logic ACT_ASSOC = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    // input word
    typedef struct packed {
        logic               action;
        logic [STAMP_W-1:0] stamp_us;
        logic [STAMP_W-1:0] prev_stamp_us;
        logic               graph_updated;
    } in_word_t;

    // result word
    typedef struct packed {
        logic [NUM_W-1:0] pose_number;
        logic             associated;
        logic             table_full;
    } out_word_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic rd;
        logic diff;
        logic decide;
        logic commit;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic new_clear;
        logic count_zero;
        logic scan_last;
        logic out_busy;
    } ctrl_sts_t;

endpackage

// File: rtl/tspa_ctrl.sv
module tspa_ctrl
    import tspa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  ctrl_sts_t sts,
    output ctrl_cmd_t cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCAN   = 6'b000010,
        S_DRAIN  = 6'b000100,
        S_DIST   = 6'b001000,
        S_DECIDE = 6'b010000,
        S_COMMIT = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // sequencing of one word: scan, distances, decision, table and output write
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (sts.new_clear)
                        state_next = S_COMMIT;
                    else if (sts.count_zero)
                        state_next = S_DIST;
                    else
                        state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.rd = 1'b1;
                if (sts.scan_last)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                state_next = S_DIST;
            end
            S_DIST:
            begin
                cmd.diff   = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                // hold until the output register is free
                if (!sts.out_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_stall = (state_reg != S_IDLE);

`ifndef SYNTHESIS
    // a scan never starts on an empty table
    a_no_empty_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && in_valid && !sts.new_clear && sts.count_zero)
        |=> state_reg == S_DIST)
        else $error("scan entered with empty table");

    // every accepted word ends in a commit before the next is taken
    a_commit_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> state_reg == S_IDLE)
        else $error("commit did not return to idle");

    // only one command at a time
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("overlapping datapath commands");
`endif

endmodule

// File: rtl/tspa_dpath.sv
module tspa_dpath
    import tspa_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  in_word_t         in_word,
    output logic             out_valid,
    input  logic             out_stall,
    output out_word_t        out_word,
    input  logic             cfg_we,
    input  logic [THR_W-1:0] cfg_data,
    input  ctrl_cmd_t        cmd,
    output ctrl_sts_t        sts
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    // table memories
    logic [STAMP_W-1:0] stamp_mem [TABLE_DEPTH];
    logic [NUM_W-1:0]   num_mem   [TABLE_DEPTH];

    in_word_t           item_reg;
    logic [THR_W-1:0]   thr_reg;
    logic [CW-1:0]      count_reg;
    logic [NUM_W-1:0]   pose_counter_reg;

    logic [IW-1:0]      scan_idx_reg;
    logic               rd_vld_reg;
    logic [IW-1:0]      rd_idx_reg;
    logic [STAMP_W-1:0] rd_stamp_reg;
    logic [NUM_W-1:0]   rd_num_reg;

    logic               have_lo_reg, have_lo_next;
    logic [STAMP_W-1:0] lo_stamp_reg, lo_stamp_next;
    logic [NUM_W-1:0]   lo_num_reg, lo_num_next;
    logic               have_hi_reg, have_hi_next;
    logic [STAMP_W-1:0] hi_stamp_reg, hi_stamp_next;
    logic [NUM_W-1:0]   hi_num_reg, hi_num_next;
    logic               eq_found_reg, eq_found_next;
    logic [IW-1:0]      eq_idx_reg, eq_idx_next;

    logic [STAMP_W-1:0] lo_d_reg;
    logic [STAMP_W-1:0] hi_d_reg;
    logic               lo_newer_reg;
    logic               hi_newer_reg;

    logic [NUM_W-1:0]   res_num_reg;
    logic               res_assoc_reg;
    logic               res_full_reg;

    logic               out_valid_reg;
    out_word_t          out_word_reg;

    logic [STAMP_W-1:0] thr_ext;
    logic               near;
    logic               pick_lo;
    logic               pick_hi;
    logic               mem_we;
    logic [IW-1:0]      wr_addr;

    // status to controller
    assign sts.new_clear  = (in_word.action == ACT_CLEAR);
    assign sts.count_zero = (count_reg == '0);
    assign sts.scan_last  = (CW'(scan_idx_reg) == count_reg - CW'(1));
    assign sts.out_busy   = out_valid_reg && out_stall;

    // threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= THR_RESET;
        else if (cfg_we)
            thr_reg <= cfg_data;
    end

    // captured word
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= in_word;
    end

    // scan address and read pipeline flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            rd_vld_reg   <= 1'b0;
            rd_idx_reg   <= '0;
        end
        else
        begin
            rd_vld_reg <= cmd.rd;
            rd_idx_reg <= scan_idx_reg;
            if (cmd.load)
                scan_idx_reg <= '0;
            else if (cmd.rd)
                scan_idx_reg <= scan_idx_reg + IW'(1);
        end
    end

    // table write on commit: overwrite an equal stamp or append while the table has room
    assign wr_addr = eq_found_reg ? eq_idx_reg : count_reg[IW-1:0];
    assign mem_we  = cmd.commit && (item_reg.action == ACT_ASSOC)
                     && (eq_found_reg || !res_full_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stamp_mem[wr_addr] <= item_reg.stamp_us;
            num_mem[wr_addr]   <= res_num_reg;
        end
        rd_stamp_reg <= stamp_mem[scan_idx_reg];
        rd_num_reg   <= num_mem[scan_idx_reg];
    end

    // neighbor tracking, one stored entry per cycle
    always_comb
    begin
        have_lo_next  = have_lo_reg;
        lo_stamp_next = lo_stamp_reg;
        lo_num_next   = lo_num_reg;
        have_hi_next  = have_hi_reg;
        hi_stamp_next = hi_stamp_reg;
        hi_num_next   = hi_num_reg;
        eq_found_next = eq_found_reg;
        eq_idx_next   = eq_idx_reg;
        if (cmd.load)
        begin
            have_lo_next  = 1'b0;
            have_hi_next  = 1'b0;
            eq_found_next = 1'b0;
        end
        else if (rd_vld_reg)
        begin
            if (rd_stamp_reg <= item_reg.stamp_us)
            begin
                if (!have_lo_reg || rd_stamp_reg > lo_stamp_reg)
                begin
                    have_lo_next  = 1'b1;
                    lo_stamp_next = rd_stamp_reg;
                    lo_num_next   = rd_num_reg;
                end
            end
            else
            begin
                if (!have_hi_reg || rd_stamp_reg < hi_stamp_reg)
                begin
                    have_hi_next  = 1'b1;
                    hi_stamp_next = rd_stamp_reg;
                    hi_num_next   = rd_num_reg;
                end
            end
            if (!eq_found_reg && rd_stamp_reg == item_reg.stamp_us)
            begin
                eq_found_next = 1'b1;
                eq_idx_next   = rd_idx_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_lo_reg  <= 1'b0;
            have_hi_reg  <= 1'b0;
            eq_found_reg <= 1'b0;
        end
        else
        begin
            have_lo_reg  <= have_lo_next;
            have_hi_reg  <= have_hi_next;
            eq_found_reg <= eq_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_stamp_reg <= lo_stamp_next;
        lo_num_reg   <= lo_num_next;
        hi_stamp_reg <= hi_stamp_next;
        hi_num_reg   <= hi_num_next;
        eq_idx_reg   <= eq_idx_next;
    end

    // distances and recency against the previous pose
    always_ff @(posedge clk)
    begin
        if (cmd.diff)
        begin
            lo_d_reg     <= item_reg.stamp_us - lo_stamp_reg;
            hi_d_reg     <= hi_stamp_reg - item_reg.stamp_us;
            lo_newer_reg <= lo_stamp_reg > item_reg.prev_stamp_us;
            hi_newer_reg <= hi_stamp_reg > item_reg.prev_stamp_us;
        end
    end

    // association decision
    assign thr_ext = STAMP_W'(thr_reg);
    assign near    = item_reg.graph_updated
                     && ((have_lo_reg && lo_d_reg < thr_ext)
                         || (have_hi_reg && hi_d_reg < thr_ext));
    assign pick_lo = near && have_lo_reg && (!have_hi_reg || hi_d_reg > lo_d_reg)
                     && lo_newer_reg;
    assign pick_hi = near && !pick_lo && have_hi_reg && hi_newer_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pose_counter_reg <= '0;
        else if (cmd.decide && !pick_lo && !pick_hi)
            pose_counter_reg <= pose_counter_reg + NUM_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.decide)
        begin
            res_assoc_reg <= pick_lo || pick_hi;
            res_full_reg  <= !eq_found_reg && (count_reg == DEPTH_C);
            if (pick_lo)
                res_num_reg <= lo_num_reg;
            else if (pick_hi)
                res_num_reg <= hi_num_reg;
            else
                res_num_reg <= pose_counter_reg + NUM_W'(1);
        end
    end

    // entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.commit)
        begin
            if (item_reg.action == ACT_CLEAR)
                count_reg <= '0;
            else if (!eq_found_reg && !res_full_reg)
                count_reg <= count_reg + CW'(1);
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.commit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            if (item_reg.action == ACT_CLEAR)
                out_word_reg <= '0;
            else
            begin
                out_word_reg.pose_number <= res_num_reg;
                out_word_reg.associated  <= res_assoc_reg;
                out_word_reg.table_full  <= res_full_reg;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

`ifndef SYNTHESIS
    // fill count stays within the table
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("entry count beyond table depth");

    // a commit never overwrites a result still waiting
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(out_valid_reg && out_stall))
        else $error("result overwritten while stalled");

    // clear empties the table
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && item_reg.action == ACT_CLEAR) |=> count_reg == '0)
        else $error("clear left entries");

    // the pose counter only moves on a decision
    a_counter_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.decide |=> $stable(pose_counter_reg))
        else $error("pose counter moved outside decision");
`endif

endmodule

// File: rtl/timestamp_pose_associator.sv
// Sequence: an associate word is captured, the stored stamps are scanned (one table read per
// cycle), the last read drains, distances and decision follow, and the result is committed once
// the output register is free; an empty table skips the scan and a clear word goes to commit.
// Throughput: one word at a time; the next word is accepted once the previous one is
// committed to the output register, while that result may still be waiting.
// Reset (rst_n, async low): table empty, pose counter 0, threshold 10000 us.
module timestamp_pose_associator
    import tspa_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_word_t         in_word,
    output logic             out_valid,
    input  logic             out_stall,
    output out_word_t        out_word,
    input  logic             cfg_we,
    input  logic [THR_W-1:0] cfg_data
);

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    // sequencer
    tspa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // table, scan and decision datapath
    tspa_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
